>>> rtl/core/tstp_pkg.sv
// ============================================================================
// tstp_pkg: track selector token parser package
// transaction types and character codes shared by the parser
// ============================================================================
package tstp_pkg;

    // input transaction kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // character codes
    localparam logic [7:0] CH_VIDEO = 8'h76;  // 'v'
    localparam logic [7:0] CH_AUDIO = 8'h61;  // 'a'
    localparam logic [7:0] CH_DASH  = 8'h2d;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // fixed widths of the transaction fields
    localparam int MASK_W  = 64;
    localparam int COUNT_W = 12;
    localparam int ACC_W   = 8;
    localparam int POS_MAX = 4095;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [MASK_W-1:0]  video_mask;
        logic [MASK_W-1:0]  audio_mask;
        logic               default_first_tracks;
        logic [COUNT_W-1:0] consumed_count;
        logic               index_out_of_range;
    } t_out;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_LETTER  = 3'b001,
        PH_DIGITS  = 3'b010,
        PH_STOPPED = 3'b100
    } t_phase;

endpackage

>>> rtl/core/track_selector_token_parser.sv
// ============================================================================
// track_selector_token_parser
// parses a track-selector string one character per transaction and returns
// the video and audio track masks at the end-of-string transaction
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (kind, ch)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (masks, flags, count)
//
//  one input transaction per cycle unless an end marker waits; an end-of-string
//  transaction goes to the output via the input register, then the result register
//  character transactions never wait on the output side; only an end marker
//  held in the input register waits while the result register is still full
//  synchronous active-low reset returns the parser to expect-first-letter with
//  cleared masks, an empty input register and an empty result register
//
module track_selector_token_parser #(
    parameter int TRACK_MASK_BITS = 64,
    parameter int MAX_STRING_LEN  = 4095
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tstp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tstp_pkg::t_out o_out_data
);
    import tstp_pkg::*;

    // characters consumed before an overlong string is cut
    localparam int            POS_LIM_I = (MAX_STRING_LEN < POS_MAX) ? MAX_STRING_LEN : POS_MAX;
    localparam logic [COUNT_W-1:0] POS_LIMIT = COUNT_W'(POS_LIM_I);
    localparam logic [ACC_W-1:0]   TRACK_LIM = ACC_W'(TRACK_MASK_BITS);

    // input register
    logic r_in_valid;
    t_in  r_in;

    // parser state
    t_phase                     r_phase,  n_phase;
    logic                       r_audio,  n_audio;
    logic [ACC_W-1:0]           r_acc,    n_acc;
    logic [TRACK_MASK_BITS-1:0] r_video,  n_video;
    logic [TRACK_MASK_BITS-1:0] r_amask,  n_amask;
    logic [COUNT_W-1:0]         r_pos,    n_pos;
    logic                       r_range,  n_range;

    // result register
    logic r_out_valid;
    t_out r_out,      n_out;

    logic                       advance;
    logic                       adv_end;
    logic                       do_apply;
    logic                       do_start;
    logic                       is_letter;
    logic                       is_digit;
    logic [TRACK_MASK_BITS-1:0] tok_bits;
    logic                       tok_over;
    logic [TRACK_MASK_BITS-1:0] a_video;
    logic [TRACK_MASK_BITS-1:0] a_amask;
    logic                       a_range;
    logic [COUNT_W-1:0]         acc_x10;
    logic [ACC_W-1:0]           acc_sat;

    // an end marker needs a free result slot, characters always move on
    assign advance    = r_in_valid && (r_in.kind == KIND_CHAR || !r_out_valid || i_out_ready);
    assign adv_end    = advance && r_in.kind == KIND_END;
    assign o_in_ready = !r_in_valid || advance;

    assign is_letter = (r_in.ch == CH_VIDEO) || (r_in.ch == CH_AUDIO);
    assign is_digit  = (r_in.ch >= CH_ZERO) && (r_in.ch <= CH_NINE);

    // index times ten plus the new digit, saturating at the accumulator top
    assign acc_x10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                   + {4'b0000, r_in.ch - CH_ZERO};
    assign acc_sat = (acc_x10 > COUNT_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : acc_x10[ACC_W-1:0];

    // mask bits of the pending token: zero index selects every track
    always_comb begin
        for (int i = 0; i < TRACK_MASK_BITS; i++) begin
            tok_bits[i] = (r_acc == '0) || (r_acc == ACC_W'(i + 1));
        end
    end
    assign tok_over = r_acc > TRACK_LIM;

    // pending token folded into the masks when do_apply is set
    assign a_video = r_video | ((do_apply && !r_audio) ? tok_bits : '0);
    assign a_amask = r_amask | ((do_apply &&  r_audio) ? tok_bits : '0);
    assign a_range = r_range | (do_apply && tok_over);

    // parse step
    always_comb begin
        do_apply = 1'b0;
        do_start = 1'b0;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_pos    = r_pos;
        if (advance) begin
            if (r_in.kind == KIND_END) begin
                do_apply = (r_phase == PH_DIGITS);
            end else if (r_phase == PH_LETTER || r_phase == PH_DIGITS) begin
                if (r_pos >= POS_LIMIT) begin
                    // overlong string: close as if the end had come
                    do_apply = (r_phase == PH_DIGITS);
                    n_phase  = PH_STOPPED;
                end else if (r_phase == PH_LETTER) begin
                    do_start = is_letter;
                    if (!is_letter) begin
                        n_phase = PH_STOPPED;
                    end
                end else if (is_digit) begin
                    n_acc = acc_sat;
                    n_pos = r_pos + COUNT_W'(1);
                end else begin
                    do_apply = 1'b1;
                    if (r_in.ch == CH_DASH) begin
                        n_phase = PH_LETTER;
                        n_pos   = r_pos + COUNT_W'(1);
                    end else if (is_letter) begin
                        do_start = 1'b1;
                    end else begin
                        n_phase = PH_STOPPED;
                    end
                end
            end
        end

        n_audio = r_audio;
        if (do_start) begin
            // new token: letter picks the media type, index starts empty
            n_audio = (r_in.ch == CH_AUDIO);
            n_acc   = '0;
            n_phase = PH_DIGITS;
            n_pos   = r_pos + COUNT_W'(1);
        end

        if (adv_end) begin
            // next string starts from the first letter
            n_phase = PH_LETTER;
            n_audio = 1'b0;
            n_acc   = '0;
            n_pos   = '0;
        end
    end

    // mask update and end-of-string result
    always_comb begin
        n_video = a_video;
        n_amask = a_amask;
        n_range = a_range;

        // result of the end marker, taken from the state with the last token applied
        n_out.video_mask           = MASK_W'(a_video);
        n_out.audio_mask           = MASK_W'(a_amask);
        n_out.default_first_tracks = (r_pos == '0);
        n_out.consumed_count       = r_pos;
        n_out.index_out_of_range   = a_range;

        if (adv_end) begin
            // masks start cleared for the next string
            n_video = '0;
            n_amask = '0;
            n_range = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LETTER;
            r_audio     <= 1'b0;
            r_acc       <= '0;
            r_video     <= '0;
            r_amask     <= '0;
            r_pos       <= '0;
            r_range     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase <= n_phase;
            r_audio <= n_audio;
            r_acc   <= n_acc;
            r_video <= n_video;
            r_amask <= n_amask;
            r_pos   <= n_pos;
            r_range <= n_range;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv_end) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an end marker blocked by a full result register stays put
    a_end_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.kind == KIND_END && r_out_valid && !i_out_ready)
        |=> (r_in_valid && $stable(r_in)))
        else $error("blocked end marker left the input register");

    // after an end marker the parser starts the next string from scratch
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_end |=> (r_phase == PH_LETTER && r_pos == '0 && r_video == '0
                     && r_amask == '0 && !r_range))
        else $error("parser state not cleared after end marker");

    // the no-token flag only goes with empty masks and nothing consumed
    a_default_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.default_first_tracks)
        |-> (o_out_data.video_mask == '0 && o_out_data.audio_mask == '0
             && o_out_data.consumed_count == '0))
        else $error("default flag with nonempty result");

    // the consumed count never passes the string limit
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("position beyond string limit");

endmodule
